FILE: hw/rtl/mqsd_pkg.sv
// ----------------------------------------------------------------------------
// Multi-queue service drain: shared package
// Types, codes and default constants used by the front end, the back end and
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsd_pkg;

  // Default configuration of the top level
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned NUM_QUEUES_DEF  = 4;
  localparam int unsigned MAX_QUEUES      = 8;

  // Field widths
  localparam int unsigned QSEL_W   = 2;
  localparam int unsigned JOB_W    = 8;
  localparam int unsigned SVC_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned ACTIVE_W = 3;
  localparam int unsigned QIDX_W   = 3;   // holds any queue index up to MAX_QUEUES-1
  localparam int unsigned LIM_W    = 4;   // holds a queue count up to MAX_QUEUES

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  // Operation codes of an input item
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Kind codes of a result item
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  // Command handed from the front end to the back end
  typedef struct packed {
    logic                is_adv;
    logic [QIDX_W-1:0]   qsel;
    logic [JOB_W-1:0]    job_id;
    logic [SVC_W-1:0]    svc;
    logic [TIME_W-1:0]   now;
    logic [DELTA_W-1:0]  delta;
    logic [LIM_W-1:0]    lim;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic                kind;
    logic [QSEL_W-1:0]   queue;
    logic [JOB_W-1:0]    job;
    logic [TIME_W-1:0]   finish;
    logic                last;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QSTART,
    ST_EVAL,
    ST_FLUSH
  } back_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/mqsd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mqsd_front.sv
// ----------------------------------------------------------------------------
// Multi-queue service drain: front end
// Holds the active queue register, accepts input transfers, drops items that
// do nothing and queues the rest as commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsd_front
  import mqsd_pkg::*;
#(
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [ACTIVE_W-1:0]   cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_op_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_pop_i,
  output cmd_t                       cmd_o
);

  logic [ACTIVE_W-1:0] active_q;
  logic [LIM_W-1:0]    lim;
  cmd_t                cmd_in;
  logic                keep;
  logic                accept;
  logic                push;

  cmd_t                fifo_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic [1:0]          cnt_q;

  // Active queue register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Clamp the walk to the queues that exist
  assign lim = (LIM_W'(active_q) > LIM_W'(NUM_QUEUES)) ? LIM_W'(NUM_QUEUES)
                                                       : LIM_W'(active_q);

  // Unpack the transfer into a command
  always_comb begin
    cmd_in.is_adv = (in_op_i == OP_ADVANCE);
    cmd_in.qsel   = QIDX_W'(in_data_i[1:0]);
    cmd_in.job_id = in_data_i[9:2];
    cmd_in.svc    = in_data_i[25:10];
    cmd_in.now    = in_data_i[57:26];
    cmd_in.delta  = in_data_i[73:58];
    cmd_in.lim    = lim;
  end

  // Drop pushes to missing queues and advances that walk no queue
  assign keep = cmd_in.is_adv ? (lim != '0) : (32'(in_data_i[1:0]) < NUM_QUEUES);

  assign in_ready_o  = (cnt_q != 2'd2);
  assign accept      = in_valid_i && in_ready_o;
  assign push        = accept && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Two-entry command queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Command queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mqsd_back.sv
// ----------------------------------------------------------------------------
// Multi-queue service drain: back end
// Keeps the ring pointers and fill counts, executes pushes and time advances
// against the job store, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsd_back
  import mqsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_QUEUES  = NUM_QUEUES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_pop_o,
  input  wire cmd_t  cmd_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_o
);

  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH * NUM_QUEUES;
  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned QCW = $clog2(NUM_QUEUES + 1);
  localparam int unsigned DW  = JOB_W + SVC_W;
  localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  back_state_e         state_q, state_d;
  logic [QCW-1:0]      q_q;
  logic [QCW-1:0]      lim_q;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   clock_q;
  logic [DELTA_W-1:0]  delta_q;
  logic [DELTA_W-1:0]  budget_q;
  logic [PW-1:0]       head_q [NUM_QUEUES];
  logic [PW-1:0]       tail_q [NUM_QUEUES];
  logic [CW-1:0]       cnt_q  [NUM_QUEUES];
  logic                pend_v_q;
  res_t                pend_q;
  logic                out_v_q;
  res_t                out_q;

  logic [QW-1:0]       cur_q;
  logic [CW-1:0]       cur_cnt;
  logic                cur_full;
  logic                cur_empty;
  logic                q_done;
  logic                out_free;
  logic [SVC_W-1:0]    t_rd;
  logic [JOB_W-1:0]    id_rd;
  logic                fits;
  logic [TIME_W-1:0]   clock_sum;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [DW-1:0]       ram_rdata;

  logic                start_adv;
  logic                push_ok;
  logic                emit;
  res_t                emit_res;
  logic                next_queue;
  logic                pop_job;
  logic                flush_go;

  // Decode the queue in work and the head job read back
  assign cur_q     = (state_q == ST_IDLE) ? cmd_i.qsel[QW-1:0] : q_q[QW-1:0];
  assign cur_cnt   = cnt_q[cur_q];
  assign cur_full  = (cur_cnt == CW'(QUEUE_DEPTH));
  assign cur_empty = (cur_cnt == '0);
  assign q_done    = (q_q == lim_q);
  assign out_free  = !out_v_q || out_ready_i;
  assign t_rd      = ram_rdata[SVC_W-1:0];
  assign id_rd     = ram_rdata[DW-1:SVC_W];
  assign fits      = (t_rd <= budget_q);
  assign clock_sum = clock_q + TIME_W'(t_rd);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.is_adv) begin
          state_d = ST_QSTART;
        end
      end
      ST_QSTART: begin
        if (q_done) begin
          state_d = ST_FLUSH;
        end else if (!cur_empty) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!fits || !pend_v_q || out_free) begin
          state_d = ST_QSTART;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    cmd_pop_o  = 1'b0;
    start_adv  = 1'b0;
    push_ok    = 1'b0;
    emit       = 1'b0;
    emit_res   = pend_q;
    next_queue = 1'b0;
    pop_job    = 1'b0;
    flush_go   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(cur_q) * DEPTH_A + AW'(head_q[cur_q]);
    ram_wdata  = {id_rd, t_rd - budget_q};
    ram_re     = 1'b0;
    ram_raddr  = AW'(cur_q) * DEPTH_A + AW'(head_q[cur_q]);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_adv) begin
            cmd_pop_o = 1'b1;
            start_adv = 1'b1;
          end else if (!cur_full) begin
            cmd_pop_o = 1'b1;
            push_ok   = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = AW'(cur_q) * DEPTH_A + AW'(tail_q[cur_q]);
            ram_wdata = {cmd_i.job_id, cmd_i.svc};
          end else if (out_free) begin
            // Report the drop right away
            cmd_pop_o       = 1'b1;
            emit            = 1'b1;
            emit_res.kind   = KIND_DROP;
            emit_res.queue  = cmd_i.qsel[QSEL_W-1:0];
            emit_res.job    = cmd_i.job_id;
            emit_res.finish = '0;
            emit_res.last   = 1'b1;
          end
        end
      end
      ST_QSTART: begin
        if (!q_done) begin
          if (cur_empty) begin
            next_queue = 1'b1;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        if (!fits) begin
          // Head job keeps the rest of its time
          ram_we     = 1'b1;
          next_queue = 1'b1;
        end else if (!pend_v_q || out_free) begin
          pop_job = 1'b1;
          if (pend_v_q) begin
            emit          = 1'b1;
            emit_res.last = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          flush_go = 1'b1;
          if (pend_v_q) begin
            emit          = 1'b1;
            emit_res.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      q_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (start_adv) begin
        q_q <= '0;
      end else if (next_queue) begin
        q_q <= q_q + QCW'(1);
      end
      if (push_ok) begin
        tail_q[cur_q] <= next_ptr(tail_q[cur_q]);
        cnt_q[cur_q]  <= cur_cnt + CW'(1);
      end else if (pop_job) begin
        head_q[cur_q] <= next_ptr(head_q[cur_q]);
        cnt_q[cur_q]  <= cur_cnt - CW'(1);
      end
      if (pop_job) begin
        pend_v_q <= 1'b1;
      end else if (flush_go) begin
        pend_v_q <= 1'b0;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Walk datapath: per-queue clock and budget, held and outgoing results
  always_ff @(posedge clk_i) begin
    if (start_adv) begin
      now_q    <= cmd_i.now;
      delta_q  <= cmd_i.delta;
      lim_q    <= cmd_i.lim[QCW-1:0];
      clock_q  <= cmd_i.now;
      budget_q <= cmd_i.delta;
    end else if (next_queue) begin
      clock_q  <= now_q;
      budget_q <= delta_q;
    end else if (pop_job) begin
      clock_q  <= clock_sum;
      budget_q <= budget_q - t_rd;
    end
    if (pop_job) begin
      pend_q.kind   <= KIND_DONE;
      pend_q.queue  <= QSEL_W'(q_q);
      pend_q.job    <= id_rd;
      pend_q.finish <= clock_sum;
      pend_q.last   <= 1'b0;
    end
    if (emit) begin
      out_q <= emit_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Job store: id above remaining time
  mqsd_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/multi_queue_service_drain_top.sv
// ----------------------------------------------------------------------------
// Multi-queue service drain: top level
// Ring-buffer job queues with push, drop reporting and time-advance draining.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser is the operation (push or advance), tdata the
// queue select, job id, service time, start time and time budget. Output
// stream (m_axis): tuser is the kind (completion or drop), tlast marks the
// final result of one input, tdata the queue, job id and finish time.
// cfg_we_i/cfg_wdata_i set the number of queues an advance walks.
// A two-entry command queue decouples the input from the executor, so input
// transfers keep flowing while a result waits in the output register.
// A push gives no result, or one drop result that passes from the command
// queue through the output register. An advance starts, walks each active
// queue in turn and reads each head job once from the job store through
// its registered read port; every job that fits the budget completes, the
// first that does not fit keeps the rest of its time, and a flush ends the walk.
// The last completion of an advance is held until the walk ends so that it
// can carry tlast.
// When m_axis_tready_i is low the executor stalls at its next result and the
// command queue fills, then s_axis_tready_o drops. Reset empties all queues
// and sets four active queues; the job store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_service_drain_top
  import mqsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_QUEUES  = NUM_QUEUES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [ACTIVE_W-1:0]   cfg_wdata_i,     // active_queues
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [1:0] queue_sel, [9:2] job_id, [25:10] service_time, [57:26] now_time,
  // [73:58] delta, [79:74] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,  // operation
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [1:0] out_queue, [9:2] out_job, [41:10] finish_time, [47:42] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tuser_o,  // kind
  output logic                       m_axis_tlast_o   // last
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  // Accept and classify
  mqsd_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Execute pushes and advances
  mqsd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // Pack the result
  assign m_axis_tdata_o = {6'd0, res.finish, res.job, res.queue};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

  // A drop is always the only result of its push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_DROP) |-> m_axis_tlast_o)
    else $error("drop result without tlast");

  // A drop carries a zero finish time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_DROP) |-> (m_axis_tdata_o[41:10] == '0))
    else $error("drop result with nonzero finish time");

  // Input backpressure only with commands waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> cmd_valid)
    else $error("input stalled with empty command queue");

  // The executor never pops an empty command queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command pop while empty");

endmodule

`default_nettype wire

FILE: tb/multi_queue_service_drain_top_tb.sv
// ----------------------------------------------------------------------------
// Multi-queue service drain: self-checking testbench
// A short directed table covers field extremes, the zero-service job, time
// wrap, an empty advance and a full-queue drop. Random phases then run under
// different active-queue settings with random stalls on both streams outside
// one steady phase. Every result transfer is checked field by field against
// expected events from a behavioral queue predictor or the directed table.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_service_drain_top_tb;
  import mqsd_pkg::*;

  localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
  localparam int unsigned NUM_Q        = NUM_QUEUES_DEF;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned STALL_PCT    = 16;
  localparam int unsigned PHASE_ITEMS  = 24;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned STEADY_PHASE = 4;

  // How a directed row states its outcome
  localparam int USE_MODEL  = -1;
  localparam int NO_RESULT  = 0;
  localparam int ONE_RESULT = 1;

  typedef struct packed {
    logic               op;
    logic [QSEL_W-1:0]  sel;
    logic [JOB_W-1:0]   id;
    logic [SVC_W-1:0]   svc;
    logic [TIME_W-1:0]  now;
    logic [DELTA_W-1:0] delta;
  } job_cmd_t;

  typedef struct {
    job_cmd_t cmd;
    int       reps;     // send the row this often, job id counting up
    int       given;
    res_t     typed;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [ACTIVE_W-1:0]   cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  // Predictor state
  logic [ACTIVE_W-1:0] active_q;
  int unsigned         q_head [NUM_Q];
  int unsigned         q_tail [NUM_Q];
  int unsigned         q_fill [NUM_Q];
  logic [JOB_W-1:0]    id_store [DEPTH*NUM_Q];
  logic [SVC_W-1:0]    svc_store [DEPTH*NUM_Q];

  res_t        fresh_events[$];
  res_t        due_events[$];
  res_t        head_want;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          steady_flow = 1'b0;
  plan_row_t   plan [10];

  multi_queue_service_drain_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multi_queue_service_drain_top: mismatch");
      $finish;
    end
  end

  // Stall the result stream at random, except in the steady stretch
  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
  end

  // Check each result transfer against the oldest expected event
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (due_events.size() == 0) begin
        $error("result with nothing expected: queue %0d job %0h",
               m_axis_tdata_o[1:0], m_axis_tdata_o[9:2]);
        err_count++;
      end else begin
        head_want = due_events.pop_front();
        if (m_axis_tuser_o !== head_want.kind) begin
          $error("kind: expected %0d, actual %0d", head_want.kind, m_axis_tuser_o);
          err_count++;
        end
        if (m_axis_tdata_o[1:0] !== head_want.queue) begin
          $error("out_queue: expected %0d, actual %0d", head_want.queue,
                 m_axis_tdata_o[1:0]);
          err_count++;
        end
        if (m_axis_tdata_o[9:2] !== head_want.job) begin
          $error("out_job: expected %0h, actual %0h", head_want.job,
                 m_axis_tdata_o[9:2]);
          err_count++;
        end
        if (m_axis_tdata_o[41:10] !== head_want.finish) begin
          $error("finish_time: expected %0h, actual %0h", head_want.finish,
                 m_axis_tdata_o[41:10]);
          err_count++;
        end
        if (m_axis_tlast_o !== head_want.last) begin
          $error("last: expected %0d, actual %0d", head_want.last, m_axis_tlast_o);
          err_count++;
        end
      end
    end
  end

  // Work out the events that one accepted command causes, updating the queues
  task automatic predict_service(input job_cmd_t c);
    int unsigned        lim;
    int unsigned        budget;
    int unsigned        slot;
    logic [TIME_W-1:0]  clock;
    fresh_events.delete();
    if (c.op == OP_PUSH) begin
      // queue_sel is two bits wide, so it never selects a missing queue
      if (q_fill[c.sel] >= DEPTH) begin
        fresh_events.push_back('{KIND_DROP, c.sel, c.id, '0, 1'b1});
      end else begin
        slot = c.sel * DEPTH + q_tail[c.sel];
        id_store[slot]  = c.id;
        svc_store[slot] = c.svc;
        q_tail[c.sel]   = (q_tail[c.sel] + 1) % DEPTH;
        q_fill[c.sel]++;
      end
    end else begin
      lim = (active_q > NUM_Q) ? NUM_Q : active_q;
      for (int q = 0; q < lim; q++) begin
        clock  = c.now;
        budget = c.delta;
        while (q_fill[q] > 0) begin
          slot = q * DEPTH + q_head[q];
          if (svc_store[slot] > budget) begin
            svc_store[slot] = SVC_W'(svc_store[slot] - budget);
            break;
          end
          budget -= svc_store[slot];
          clock  += svc_store[slot];
          fresh_events.push_back('{KIND_DONE, q[QSEL_W-1:0], id_store[slot], clock, 1'b0});
          q_head[q] = (q_head[q] + 1) % DEPTH;
          q_fill[q]--;
        end
      end
      if (fresh_events.size() > 0) fresh_events[$].last = 1'b1;
    end
  endtask

  // Offer one command, hold it until the transfer, then record its events
  task automatic issue(input job_cmd_t c, input int given, input res_t typed);
    while (!steady_flow && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {{(IN_DATA_W-74){1'b0}}, c.delta, c.now, c.svc, c.id, c.sel};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_service(c);
    if (given == USE_MODEL) begin
      foreach (fresh_events[i]) due_events.push_back(fresh_events[i]);
    end else if (given == ONE_RESULT) begin
      due_events.push_back(typed);
    end
  endtask

  // Drop valid, wait for every expected event, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [ACTIVE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    active_q  = value;
  endtask

  initial begin
    job_cmd_t                 cmd;
    logic [ACTIVE_W-1:0]      phase_active [NUM_PHASES];
    int unsigned              push_pct [NUM_PHASES];
    int unsigned              pick;

    phase_active = '{3'd7, 3'd1, 3'd0, 3'd3, 3'd4, 3'd5, 3'd2, 3'd6};
    push_pct     = '{60, 75, 85, 55, 65, 90, 50, 60};

    // Directed table: op, sel, id, svc, now, delta, reps, outcome, typed event
    plan[0] = '{'{OP_ADVANCE, 2'd0, 8'h00, 16'd0,      32'd0,         16'd0},
                1, NO_RESULT, '0};
    plan[1] = '{'{OP_PUSH,    2'd0, 8'h00, 16'd1,      32'd0,         16'd0},
                1, NO_RESULT, '0};
    plan[2] = '{'{OP_PUSH,    2'd0, 8'hFF, 16'hFFFF,   32'd0,         16'd0},
                1, NO_RESULT, '0};
    plan[3] = '{'{OP_PUSH,    2'd3, 8'h5A, 16'd0,      32'd0,         16'd0},
                1, NO_RESULT, '0};
    // zero service time completes at once, even with no budget
    plan[4] = '{'{OP_ADVANCE, 2'd0, 8'h00, 16'd0,      32'hFFFF_FFFF, 16'd0},
                1, ONE_RESULT, '{KIND_DONE, 2'd3, 8'h5A, 32'hFFFF_FFFF, 1'b1}};
    // finish time wraps; the long job keeps one unit
    plan[5] = '{'{OP_ADVANCE, 2'd0, 8'h00, 16'd0,      32'hFFFF_FFFF, 16'hFFFF},
                1, ONE_RESULT, '{KIND_DONE, 2'd0, 8'h00, 32'd0, 1'b1}};
    plan[6] = '{'{OP_ADVANCE, 2'd0, 8'h00, 16'd0,      32'd100,       16'd1},
                1, ONE_RESULT, '{KIND_DONE, 2'd0, 8'hFF, 32'd101, 1'b1}};
    plan[7] = '{'{OP_PUSH,    2'd2, 8'h80, 16'd2,      32'd0,         16'd0},
                DEPTH, USE_MODEL, '0};
    // full queue drops the push
    plan[8] = '{'{OP_PUSH,    2'd2, 8'hC3, 16'd7,      32'd0,         16'd0},
                1, ONE_RESULT, '{KIND_DROP, 2'd2, 8'hC3, 32'd0, 1'b1}};
    plan[9] = '{'{OP_ADVANCE, 2'd1, 8'h00, 16'd0,      32'd0,         16'hFFFF},
                1, USE_MODEL, '0};

    // Reset the predictor and the block
    active_q = ACTIVE_RESET;
    foreach (q_head[q]) begin
      q_head[q] = 0;
      q_tail[q] = 0;
      q_fill[q] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part
    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        cmd    = plan[r].cmd;
        cmd.id = cmd.id + JOB_W'(k);
        issue(cmd, plan[r].given, plan[r].typed);
      end
    end
    settle();

    // Random phases, one active-queue setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(phase_active[p]);
      steady_flow = (p == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd.op  = ($urandom_range(99) < push_pct[p]) ? OP_PUSH : OP_ADVANCE;
        cmd.sel = QSEL_W'($urandom_range(NUM_Q - 1));
        cmd.id  = JOB_W'($urandom_range(255));
        pick    = $urandom_range(99);
        if (pick < 5) begin
          cmd.svc = '0;
        end else if (pick < 13) begin
          cmd.svc = SVC_W'($urandom_range(16'hFFFF));
        end else begin
          cmd.svc = SVC_W'($urandom_range(24, 1));
        end
        cmd.now = $urandom();
        pick    = $urandom_range(99);
        if (pick < 8) begin
          cmd.delta = DELTA_W'($urandom_range(16'hFFFF));
        end else if (pick < 12) begin
          cmd.delta = '0;
        end else begin
          cmd.delta = DELTA_W'($urandom_range(80));
        end
        issue(cmd, USE_MODEL, '0);
      end
      steady_flow = 1'b0;
      settle();
    end

    if (err_count == 0) begin
      $display("multi_queue_service_drain_top: match");
    end else begin
      $display("multi_queue_service_drain_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
